### src/fcbb_pkg.sv
// Package for the frame change bounding box unit.
// Holds channel and register widths, reset values, register indexes and the
// shared structs. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package fcbb_pkg;

   // Pixel and arithmetic widths
   localparam int CHANNEL_BITS = 8;
   localparam int WEIGHT_BITS  = 16;
   localparam int SQUARE_BITS  = 2 * CHANNEL_BITS;
   localparam int SUM_BITS     = SQUARE_BITS + 2;

   // Default frame size limit
   localparam int MAX_DIM = 4096;

   // Register widths and the configuration port
   localparam int DIM_BITS       = 13;
   localparam int THRESH_BITS    = 18;
   localparam int CSR_DATA_BITS  = 18;
   localparam int CSR_INDEX_BITS = 3;

   // Result field widths
   localparam int START_BITS = 12;
   localparam int END_BITS   = 13;

   // Register reset values
   localparam logic [DIM_BITS-1:0]    FRAME_WIDTH_RESET  = 13'd4096;
   localparam logic [DIM_BITS-1:0]    FRAME_HEIGHT_RESET = 13'd4096;
   localparam logic [THRESH_BITS-1:0] THRESHOLD_RESET    = 18'd40000;
   localparam logic [WEIGHT_BITS-1:0] RED_WEIGHT_RESET   = 16'd13933;
   localparam logic [WEIGHT_BITS-1:0] GREEN_WEIGHT_RESET = 16'd46871;
   localparam logic [WEIGHT_BITS-1:0] BLUE_WEIGHT_RESET  = 16'd5059;

   // Register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FRAME_WIDTH      = 3'd0,
      CSR_FRAME_HEIGHT     = 3'd1,
      CSR_CHANGE_THRESHOLD = 3'd2,
      CSR_RED_WEIGHT       = 3'd3,
      CSR_GREEN_WEIGHT     = 3'd4,
      CSR_BLUE_WEIGHT      = 3'd5
   } csr_index_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_WEIGH  = 2'd1,
      ST_SQUARE = 2'd2,
      ST_TEST   = 2'd3
   } state_type;

   typedef struct packed {
      logic [DIM_BITS-1:0]    frame_width;
      logic [DIM_BITS-1:0]    frame_height;
      logic [THRESH_BITS-1:0] change_threshold;
      logic [WEIGHT_BITS-1:0] red_weight_q16;
      logic [WEIGHT_BITS-1:0] green_weight_q16;
      logic [WEIGHT_BITS-1:0] blue_weight_q16;
   } cfg_type;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] prev_red;
      logic [CHANNEL_BITS-1:0] prev_green;
      logic [CHANNEL_BITS-1:0] prev_blue;
      logic [CHANNEL_BITS-1:0] prev_opacity;
      logic [CHANNEL_BITS-1:0] cur_red;
      logic [CHANNEL_BITS-1:0] cur_green;
      logic [CHANNEL_BITS-1:0] cur_blue;
      logic [CHANNEL_BITS-1:0] cur_opacity;
   } pixel_pair_type;

   typedef struct packed {
      logic                  changed;
      logic [START_BITS-1:0] left;
      logic [START_BITS-1:0] top;
      logic [END_BITS-1:0]   right_excl;
      logic [END_BITS-1:0]   bottom_excl;
   } result_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic weigh;
      logic square;
      logic test;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic frame_end;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

### src/fcbb_req_if.sv
// Input channel of the frame change bounding box unit: one pixel pair per
// transaction. Depends on fcbb_pkg for the channel width.
`timescale 1ns / 1ps
`default_nettype none

interface fcbb_req_if;
   logic                            valid;
   logic                            ready;
   logic [fcbb_pkg::CHANNEL_BITS-1:0] prev_red;
   logic [fcbb_pkg::CHANNEL_BITS-1:0] prev_green;
   logic [fcbb_pkg::CHANNEL_BITS-1:0] prev_blue;
   logic [fcbb_pkg::CHANNEL_BITS-1:0] prev_opacity;
   logic [fcbb_pkg::CHANNEL_BITS-1:0] cur_red;
   logic [fcbb_pkg::CHANNEL_BITS-1:0] cur_green;
   logic [fcbb_pkg::CHANNEL_BITS-1:0] cur_blue;
   logic [fcbb_pkg::CHANNEL_BITS-1:0] cur_opacity;

   modport source (
      output valid, prev_red, prev_green, prev_blue, prev_opacity,
             cur_red, cur_green, cur_blue, cur_opacity,
      input  ready
   );

   modport sink (
      input  valid, prev_red, prev_green, prev_blue, prev_opacity,
             cur_red, cur_green, cur_blue, cur_opacity,
      output ready
   );
endinterface

`default_nettype wire

### src/fcbb_rsp_if.sv
// Result channel of the frame change bounding box unit: one box per frame
// per transaction. Depends on fcbb_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface fcbb_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            changed;
   logic [fcbb_pkg::START_BITS-1:0] left;
   logic [fcbb_pkg::START_BITS-1:0] top;
   logic [fcbb_pkg::END_BITS-1:0]   right_excl;
   logic [fcbb_pkg::END_BITS-1:0]   bottom_excl;

   modport source (
      output valid, changed, left, top, right_excl, bottom_excl,
      input  ready
   );

   modport sink (
      input  valid, changed, left, top, right_excl, bottom_excl,
      output ready
   );
endinterface

`default_nettype wire

### src/fcbb_csr.sv
// Configuration registers of the frame change bounding box unit.
// Depends on fcbb_pkg for register indexes, widths and reset values.
`timescale 1ns / 1ps
`default_nettype none

module fcbb_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_enable,
   input  wire logic [fcbb_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [fcbb_pkg::CSR_DATA_BITS-1:0]  csr_write_data,
   output fcbb_pkg::cfg_type                        cfg
);

   fcbb_pkg::cfg_type cfg_ff;
   fcbb_pkg::cfg_type cfg_in;

   // Decode the write; unknown indexes leave everything alone
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (fcbb_pkg::csr_index_type'(csr_index))
            fcbb_pkg::CSR_FRAME_WIDTH:
               cfg_in.frame_width = csr_write_data[fcbb_pkg::DIM_BITS-1:0];
            fcbb_pkg::CSR_FRAME_HEIGHT:
               cfg_in.frame_height = csr_write_data[fcbb_pkg::DIM_BITS-1:0];
            fcbb_pkg::CSR_CHANGE_THRESHOLD:
               cfg_in.change_threshold = csr_write_data[fcbb_pkg::THRESH_BITS-1:0];
            fcbb_pkg::CSR_RED_WEIGHT:
               cfg_in.red_weight_q16 = csr_write_data[fcbb_pkg::WEIGHT_BITS-1:0];
            fcbb_pkg::CSR_GREEN_WEIGHT:
               cfg_in.green_weight_q16 = csr_write_data[fcbb_pkg::WEIGHT_BITS-1:0];
            fcbb_pkg::CSR_BLUE_WEIGHT:
               cfg_in.blue_weight_q16 = csr_write_data[fcbb_pkg::WEIGHT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // Hold the registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width      <= fcbb_pkg::FRAME_WIDTH_RESET;
         cfg_ff.frame_height     <= fcbb_pkg::FRAME_HEIGHT_RESET;
         cfg_ff.change_threshold <= fcbb_pkg::THRESHOLD_RESET;
         cfg_ff.red_weight_q16   <= fcbb_pkg::RED_WEIGHT_RESET;
         cfg_ff.green_weight_q16 <= fcbb_pkg::GREEN_WEIGHT_RESET;
         cfg_ff.blue_weight_q16  <= fcbb_pkg::BLUE_WEIGHT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### src/fcbb_ctrl.sv
// Controller of the frame change bounding box unit: sequences one pixel pair
// through weigh, square and test steps. Depends on fcbb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcbb_ctrl (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  fcbb_pkg::status_type status,
   output fcbb_pkg::cmd_type    cmd
);

   fcbb_pkg::state_type state_ff;
   fcbb_pkg::state_type state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fcbb_pkg::ST_IDLE: begin
            if (req_valid) state_in = fcbb_pkg::ST_WEIGH;
         end
         fcbb_pkg::ST_WEIGH:  state_in = fcbb_pkg::ST_SQUARE;
         fcbb_pkg::ST_SQUARE: state_in = fcbb_pkg::ST_TEST;
         fcbb_pkg::ST_TEST: begin
            // hold while a frame result waits for the output register
            if (!(status.frame_end && !status.out_free)) state_in = fcbb_pkg::ST_IDLE;
         end
         default: state_in = fcbb_pkg::ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         fcbb_pkg::ST_IDLE: begin
            req_ready  = !reset;
            cmd.accept = !reset && req_valid;
         end
         fcbb_pkg::ST_WEIGH:  cmd.weigh  = 1'b1;
         fcbb_pkg::ST_SQUARE: cmd.square = 1'b1;
         fcbb_pkg::ST_TEST:   cmd.test   = !(status.frame_end && !status.out_free);
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fcbb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### src/fcbb_datapath.sv
// Datapath of the frame change bounding box unit: pixel position counters,
// weighted squared difference, bounding box and result register.
// Depends on fcbb_pkg for widths and structs.
`timescale 1ns / 1ps
`default_nettype none

module fcbb_datapath #(
   parameter int MAX_DIM = fcbb_pkg::MAX_DIM
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  fcbb_pkg::cfg_type        cfg,
   input  fcbb_pkg::cmd_type        cmd,
   output fcbb_pkg::status_type     status,
   input  fcbb_pkg::pixel_pair_type pixel,
   input  wire logic               rsp_ready,
   output logic                    rsp_valid,
   output fcbb_pkg::result_type     result
);

   localparam int CW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int EW  = $clog2(MAX_DIM + 1);
   localparam int CB  = fcbb_pkg::CHANNEL_BITS;
   localparam int WB  = fcbb_pkg::WEIGHT_BITS;
   localparam int SQB = fcbb_pkg::SQUARE_BITS;
   localparam int SB  = fcbb_pkg::SUM_BITS;

   // Position and box state
   logic [CW-1:0] col_ff, col_in, row_ff, row_in;
   logic          box_valid_ff, box_valid_in;
   logic [CW-1:0] start_x_ff, start_x_in, start_y_ff, start_y_in;
   logic [EW-1:0] end_x_ff, end_x_in, end_y_ff, end_y_in;
   logic          out_valid_ff, out_valid_in;

   // Per-item working registers
   logic [CW-1:0] pos_col_ff, pos_row_ff;
   logic          frame_end_ff;
   logic [CB-1:0] mag_r_ff, mag_g_ff, mag_b_ff, mag_a_ff;
   logic [CB-1:0] wt_r_ff, wt_g_ff, wt_b_ff, wt_a_ff;
   logic [SQB-1:0] sq_r_ff, sq_g_ff, sq_b_ff, sq_a_ff;
   fcbb_pkg::result_type result_ff, result_in;

   logic [EW-1:0] width_eff, height_eff;
   logic          col_last, row_last;
   logic [CB-1:0] mag_r, mag_g, mag_b, mag_a;
   logic [CB+WB-1:0] prod_r, prod_g, prod_b;
   logic [SB-1:0] sum;
   logic          hit;
   logic [EW-1:0] pos_col_next, pos_row_next;
   logic          grow_valid;
   logic [CW-1:0] grow_sx, grow_sy;
   logic [EW-1:0] grow_ex, grow_ey;

   function automatic logic [CB-1:0] abs_diff(input logic [CB-1:0] a, input logic [CB-1:0] b);
      abs_diff = (a >= b) ? (a - b) : (b - a);
   endfunction

   // Clamp frame size: zero acts as one, anything above the limit as the limit
   always_comb begin
      if (cfg.frame_width == '0) begin
         width_eff = EW'(1);
      end else if (32'(cfg.frame_width) > MAX_DIM) begin
         width_eff = EW'(MAX_DIM);
      end else begin
         width_eff = EW'(cfg.frame_width);
      end
      if (cfg.frame_height == '0) begin
         height_eff = EW'(1);
      end else if (32'(cfg.frame_height) > MAX_DIM) begin
         height_eff = EW'(MAX_DIM);
      end else begin
         height_eff = EW'(cfg.frame_height);
      end
   end

   // Advance the raster position on each accepted transaction
   always_comb begin
      col_last = (EW'(col_ff) + EW'(1)) >= width_eff;
      row_last = (EW'(row_ff) + EW'(1)) >= height_eff;
      col_in   = col_ff;
      row_in   = row_ff;
      if (cmd.accept) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + CW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   // Channel magnitudes, weights, the sum of squares and the threshold test
   always_comb begin
      mag_r  = abs_diff(pixel.prev_red, pixel.cur_red);
      mag_g  = abs_diff(pixel.prev_green, pixel.cur_green);
      mag_b  = abs_diff(pixel.prev_blue, pixel.cur_blue);
      mag_a  = abs_diff(pixel.prev_opacity, pixel.cur_opacity);
      prod_r = (CB+WB)'(mag_r_ff) * (CB+WB)'(cfg.red_weight_q16);
      prod_g = (CB+WB)'(mag_g_ff) * (CB+WB)'(cfg.green_weight_q16);
      prod_b = (CB+WB)'(mag_b_ff) * (CB+WB)'(cfg.blue_weight_q16);
      sum    = SB'(sq_r_ff) + SB'(sq_g_ff) + SB'(sq_b_ff) + SB'(sq_a_ff);
      hit    = 32'(sum) > 32'(cfg.change_threshold);
   end

   // Grow the box by the tested pixel
   always_comb begin
      pos_col_next = EW'(pos_col_ff) + EW'(1);
      pos_row_next = EW'(pos_row_ff) + EW'(1);
      grow_valid   = box_valid_ff;
      grow_sx      = start_x_ff;
      grow_sy      = start_y_ff;
      grow_ex      = end_x_ff;
      grow_ey      = end_y_ff;
      if (hit) begin
         grow_valid = 1'b1;
         if (box_valid_ff) begin
            if (pos_col_ff < start_x_ff) grow_sx = pos_col_ff;
            if (pos_row_ff < start_y_ff) grow_sy = pos_row_ff;
            if (pos_col_next > end_x_ff) grow_ex = pos_col_next;
            if (pos_row_next > end_y_ff) grow_ey = pos_row_next;
         end else begin
            grow_sx = pos_col_ff;
            grow_sy = pos_row_ff;
            grow_ex = pos_col_next;
            grow_ey = pos_row_next;
         end
      end
   end

   // Commit the test step: update box, clear it and load the result at frame end
   always_comb begin
      box_valid_in = box_valid_ff;
      start_x_in   = start_x_ff;
      start_y_in   = start_y_ff;
      end_x_in     = end_x_ff;
      end_y_in     = end_y_ff;
      result_in    = result_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      if (cmd.test) begin
         if (frame_end_ff) begin
            box_valid_in          = 1'b0;
            start_x_in            = '0;
            start_y_in            = '0;
            end_x_in              = '0;
            end_y_in              = '0;
            result_in.changed     = grow_valid;
            result_in.left        = fcbb_pkg::START_BITS'(grow_sx);
            result_in.top         = fcbb_pkg::START_BITS'(grow_sy);
            result_in.right_excl  = fcbb_pkg::END_BITS'(grow_ex);
            result_in.bottom_excl = fcbb_pkg::END_BITS'(grow_ey);
            out_valid_in          = 1'b1;
         end else begin
            box_valid_in = grow_valid;
            start_x_in   = grow_sx;
            start_y_in   = grow_sy;
            end_x_in     = grow_ex;
            end_y_in     = grow_ey;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         box_valid_ff <= 1'b0;
         start_x_ff   <= '0;
         start_y_ff   <= '0;
         end_x_ff     <= '0;
         end_y_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         box_valid_ff <= box_valid_in;
         start_x_ff   <= start_x_in;
         start_y_ff   <= start_y_in;
         end_x_ff     <= end_x_in;
         end_y_ff     <= end_y_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Per-item payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pos_col_ff   <= col_ff;
         pos_row_ff   <= row_ff;
         frame_end_ff <= col_last && row_last;
         mag_r_ff     <= mag_r;
         mag_g_ff     <= mag_g;
         mag_b_ff     <= mag_b;
         mag_a_ff     <= mag_a;
      end
      if (cmd.weigh) begin
         wt_r_ff <= prod_r[CB+WB-1:WB];
         wt_g_ff <= prod_g[CB+WB-1:WB];
         wt_b_ff <= prod_b[CB+WB-1:WB];
         wt_a_ff <= mag_a_ff;
      end
      if (cmd.square) begin
         sq_r_ff <= SQB'(wt_r_ff) * SQB'(wt_r_ff);
         sq_g_ff <= SQB'(wt_g_ff) * SQB'(wt_g_ff);
         sq_b_ff <= SQB'(wt_b_ff) * SQB'(wt_b_ff);
         sq_a_ff <= SQB'(wt_a_ff) * SQB'(wt_a_ff);
      end
      result_ff <= result_in;
   end

   assign status.frame_end = frame_end_ff;
   assign status.out_free  = !out_valid_ff || rsp_ready;
   assign rsp_valid        = out_valid_ff;
   assign result           = result_ff;

endmodule

`default_nettype wire

### src/frame_change_bounding_box_unit.sv
// Frame change bounding box unit: top level joining registers, controller
// and datapath. Depends on fcbb_pkg, fcbb_req_if, fcbb_rsp_if, fcbb_csr,
// fcbb_ctrl and fcbb_datapath.
//
// Usage: pixel pairs (previous and current frame, same position) enter on
// req in raster order, one per transaction. Each pair's red, green and blue
// differences are weighted, all four are squared and summed, and a sum above
// the threshold grows the changed-pixel box. After the last pixel of a frame
// one transaction on rsp carries the box and the changed flag, and the box
// starts over. Frame size, threshold and weights are to be set on the csr
// write port while no pixel is in flight; the block itself does not enforce this.
// Flow: the controller steps one pair at a time (accept, weigh, square,
// test) through the three register stages and takes a new pair after test.
// Result: loaded in the test step of the frame's last pair. It waits in
// an output register; pairs keep flowing while it waits, and only the
// next frame's last pair holds in its test step until the receiver takes
// the earlier result.
// Reset: registers return to their defaults, the position returns to the
// first pixel, the box is cleared and no result is pending.
`timescale 1ns / 1ps
`default_nettype none

module frame_change_bounding_box_unit #(
   parameter int MAX_DIM = fcbb_pkg::MAX_DIM
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_enable,
   input  wire logic [fcbb_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [fcbb_pkg::CSR_DATA_BITS-1:0]  csr_write_data,
   fcbb_req_if.sink                                 req_if,
   fcbb_rsp_if.source                               rsp_if
);

   fcbb_pkg::cfg_type        cfg;
   fcbb_pkg::cmd_type        cmd;
   fcbb_pkg::status_type     status;
   fcbb_pkg::pixel_pair_type pixel;
   fcbb_pkg::result_type     result;
   logic                     req_ready;
   logic                     rsp_valid;

   // Pack the incoming transaction
   always_comb begin
      pixel.prev_red     = req_if.prev_red;
      pixel.prev_green   = req_if.prev_green;
      pixel.prev_blue    = req_if.prev_blue;
      pixel.prev_opacity = req_if.prev_opacity;
      pixel.cur_red      = req_if.cur_red;
      pixel.cur_green    = req_if.cur_green;
      pixel.cur_blue     = req_if.cur_blue;
      pixel.cur_opacity  = req_if.cur_opacity;
   end

   fcbb_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   fcbb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   fcbb_datapath #(
      .MAX_DIM (MAX_DIM)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .status    (status),
      .pixel     (pixel),
      .rsp_ready (rsp_if.ready),
      .rsp_valid (rsp_valid),
      .result    (result)
   );

   // Drive the channels
   assign req_if.ready       = req_ready;
   assign rsp_if.valid       = rsp_valid;
   assign rsp_if.changed     = result.changed;
   assign rsp_if.left        = result.left;
   assign rsp_if.top         = result.top;
   assign rsp_if.right_excl  = result.right_excl;
   assign rsp_if.bottom_excl = result.bottom_excl;

`ifndef ASSERT_OFF
   // One pixel at a time: no accept right after an accept
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("input accepted while a pixel is in flight");

   // A new result traces back to the accept that caused it, through the weigh, square and test steps
   a_result_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_if.valid) |-> $past(req_if.valid && req_if.ready, 4))
      else $error("result appeared without a matching accept");

   // The controller never commits a frame end into an occupied output register
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(cmd.test && status.frame_end && !status.out_free))
      else $error("frame result would overwrite a pending result");
`endif

endmodule

`default_nettype wire
